FILE: src/i2cmbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cmbe_pkg;

  // Phase register, one-hot encoded.
  typedef enum logic [8:0] {
    PH_IDLE     = 9'b0_0000_0001,
    PH_START    = 9'b0_0000_0010,
    PH_FALL_BIT = 9'b0_0000_0100,
    PH_BIT      = 9'b0_0000_1000,
    PH_FALL_ACK = 9'b0_0001_0000,
    PH_ACK0     = 9'b0_0010_0000,
    PH_ACK1     = 9'b0_0100_0000,
    PH_AFTER    = 9'b0_1000_0000,
    PH_STOP1    = 9'b1_0000_0000
  } phase_e;

  // Command flag bit positions.
  localparam int unsigned CfStart = 0;
  localparam int unsigned CfStop  = 1;
  localparam int unsigned CfRead  = 2;
  localparam int unsigned CfTen   = 3;

  // Event flag bit positions.
  localparam int unsigned EvStarted = 0;
  localparam int unsigned EvAddr    = 1;
  localparam int unsigned EvTen     = 2;
  localparam int unsigned EvTxEmpty = 3;
  localparam int unsigned EvNack    = 4;

  localparam int unsigned FlagW  = 4;
  localparam int unsigned EventW = 5;
  localparam int unsigned AdW    = 10;
  localparam int unsigned ShiftW = 16;
  localparam int unsigned PtrW   = 5;

  // Bit pointer values that end a byte (after the ten-bit header, after the last byte), then start values.
  localparam logic [PtrW-1:0] PtrHeaderEnd = 5'd8;
  localparam logic [PtrW-1:0] PtrByteEnd   = 5'd0;
  localparam logic [PtrW-1:0] PtrByte      = 5'd8;
  localparam logic [PtrW-1:0] PtrTenBit    = 5'd16;

  // Upper bits of the ten-bit address header (11110 before A9 A8).
  localparam logic [4:0] TenBitPrefix = 5'b11110;

endpackage

FILE: src/i2c_master_bit_engine.sv
// I2C master bit engine: command/tick input, one registered result per transaction.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  mode, command_flags, address_or_data,
//                                                sda_in, scl_in
//   out      output     out_valid_o/out_stall_i  scl/sda level and drive, busy_res,
//                                                rejected, done_res, irq_flags, read_byte
//   cfg      input      cfg_we_i                 cfg_wdata_i (irq_enable)
//
// One input transaction per cycle while not stalled; its result appears in the output
// register on the next cycle, held by the single result register after the phase logic.
// Reset clears the phase machine and flags, and drives both bus lines high.
// A stalled result holds in the output register; input is stalled only while that
// register is full and the output side stalls.
module i2c_master_bit_engine
  import i2cmbe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              mode_i,
  input  logic [FlagW-1:0]  command_flags_i,
  input  logic [AdW-1:0]    address_or_data_i,
  input  logic              sda_in_i,
  input  logic              scl_in_i,
  // output channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              scl_level_o,
  output logic              scl_drive_o,
  output logic              sda_level_o,
  output logic              sda_drive_o,
  output logic              busy_res_o,
  output logic              rejected_o,
  output logic              done_res_o,
  output logic [EventW-1:0] irq_flags_o,
  output logic [7:0]        read_byte_o,
  // configuration
  input  logic              cfg_we_i,
  input  logic [EventW-1:0] cfg_wdata_i
);

  // Engine state.
  phase_e              phase_q, phase_d;
  logic [ShiftW-1:0]   shifter_q, shifter_d;
  logic [PtrW-1:0]     bit_ptr_q, bit_ptr_d;
  logic [FlagW-1:0]    pend_q, pend_d;
  logic [EventW-1:0]   event_q, event_d;
  logic                busy_q, busy_d;
  logic                scl_lv_q, scl_lv_d, scl_dr_q, scl_dr_d;
  logic                sda_lv_q, sda_lv_d, sda_dr_q, sda_dr_d;
  logic [EventW-1:0]   irq_en_q;

  // Result register.
  logic                out_valid_q;
  logic                res_scl_lv_q, res_scl_dr_q, res_sda_lv_q, res_sda_dr_q;
  logic                res_busy_q, res_rej_q, res_done_q;
  logic [EventW-1:0]   res_irq_q;
  logic [7:0]          res_rbyte_q;

  logic                accept;
  logic                done_d, rej_d;
  logic                recv_d;
  logic [7:0]          rbyte_d;

  // Stall input only when a finished result is still waiting downstream.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Load a command when idle (refused when busy) and run one half-bit phase while busy.
  always_comb begin
    logic            run;
    logic            recv;
    logic            rd;
    logic [3:0]      idx;
    logic [PtrW-1:0] ptr_dec;

    phase_d   = phase_q;
    shifter_d = shifter_q;
    bit_ptr_d = bit_ptr_q;
    pend_d    = pend_q;
    event_d   = event_q;
    busy_d    = busy_q;
    scl_lv_d  = scl_lv_q;
    scl_dr_d  = scl_dr_q;
    sda_lv_d  = sda_lv_q;
    sda_dr_d  = sda_dr_q;
    done_d    = 1'b0;
    rej_d     = 1'b0;
    run       = 1'b0;
    rd        = command_flags_i[CfRead];

    if (mode_i) begin
      if (busy_q) begin
        rej_d = 1'b1;
      end else begin
        busy_d  = 1'b1;
        event_d = '0;
        pend_d  = command_flags_i;
        run     = 1'b1;
        if (command_flags_i[CfStart]) begin
          phase_d = PH_START;
          if (command_flags_i[CfTen]) begin
            shifter_d = {TenBitPrefix[4:1], TenBitPrefix[0], address_or_data_i[9:8], rd,
                         address_or_data_i[7:0]};
            bit_ptr_d = PtrTenBit;
          end else begin
            shifter_d = {8'd0, address_or_data_i[6:0], rd};
            bit_ptr_d = PtrByte;
          end
        end else begin
          phase_d   = PH_BIT;
          shifter_d = rd ? '0 : {8'd0, address_or_data_i[7:0]};
          bit_ptr_d = PtrByte;
        end
      end
    end else if (busy_q) begin
      run = 1'b1;
    end

    recv    = pend_d[CfRead] & ~pend_d[CfStart];
    ptr_dec = bit_ptr_d - 1'b1;
    idx     = ptr_dec[3:0];

    if (run) begin
      unique case (phase_d)
        PH_START: begin
          sda_lv_d = 1'b0;
          sda_dr_d = 1'b1;
          event_d[EvStarted] = 1'b1;
          phase_d = PH_FALL_BIT;
        end
        PH_FALL_BIT: begin
          scl_lv_d = 1'b0;
          scl_dr_d = 1'b1;
          phase_d  = PH_BIT;
        end
        PH_FALL_ACK: begin
          scl_lv_d = 1'b0;
          scl_dr_d = 1'b1;
          phase_d  = PH_ACK0;
        end
        PH_BIT: begin
          if (recv) begin
            sda_dr_d = 1'b0;
            if (sda_in_i) shifter_d = shifter_d | (ShiftW'(1) << idx);
          end else begin
            sda_dr_d = 1'b1;
            sda_lv_d = shifter_d[idx];
          end
          scl_lv_d  = 1'b1;
          scl_dr_d  = 1'b1;
          bit_ptr_d = ptr_dec;
          if (ptr_dec == PtrHeaderEnd || ptr_dec == PtrByteEnd) begin
            if (pend_d[CfStart]) begin
              if (ptr_dec == PtrHeaderEnd) event_d[EvTen] = 1'b1;
              else event_d[EvAddr] = 1'b1;
            end else begin
              event_d[EvTxEmpty] = 1'b1;
            end
            phase_d = PH_FALL_ACK;
          end else begin
            phase_d = PH_FALL_BIT;
          end
        end
        PH_ACK0: begin
          sda_dr_d = 1'b0;
          scl_dr_d = 1'b0;
          // hold here while the slave stretches the clock
          if (scl_in_i) begin
            scl_lv_d = 1'b1;
            scl_dr_d = 1'b1;
            if (sda_in_i) event_d[EvNack] = 1'b1;
            phase_d = PH_ACK1;
          end
        end
        PH_ACK1: begin
          if (sda_in_i) event_d[EvNack] = 1'b1;
          scl_lv_d = 1'b0;
          scl_dr_d = 1'b1;
          sda_lv_d = 1'b0;
          sda_dr_d = 1'b1;
          phase_d  = (bit_ptr_d == PtrHeaderEnd) ? PH_BIT : PH_AFTER;
        end
        PH_AFTER: begin
          if (pend_d[CfStop]) begin
            scl_lv_d = 1'b1;
            scl_dr_d = 1'b1;
            phase_d  = PH_STOP1;
          end else begin
            busy_d  = 1'b0;
            done_d  = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        PH_STOP1: begin
          sda_lv_d = 1'b1;
          sda_dr_d = 1'b1;
          busy_d   = 1'b0;
          done_d   = 1'b1;
          phase_d  = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    recv_d  = recv;
    rbyte_d = recv_d ? shifter_d[7:0] : 8'd0;
  end

  // Advance engine state on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      shifter_q <= '0;
      bit_ptr_q <= '0;
      pend_q    <= '0;
      event_q   <= '0;
      busy_q    <= 1'b0;
      scl_lv_q  <= 1'b1;
      scl_dr_q  <= 1'b1;
      sda_lv_q  <= 1'b1;
      sda_dr_q  <= 1'b1;
    end else if (accept) begin
      phase_q   <= phase_d;
      shifter_q <= shifter_d;
      bit_ptr_q <= bit_ptr_d;
      pend_q    <= pend_d;
      event_q   <= event_d;
      busy_q    <= busy_d;
      scl_lv_q  <= scl_lv_d;
      scl_dr_q  <= scl_dr_d;
      sda_lv_q  <= sda_lv_d;
      sda_dr_q  <= sda_dr_d;
    end
  end

  // Interrupt enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_en_q <= '0;
    end else if (cfg_we_i) begin
      irq_en_q <= cfg_wdata_i;
    end
  end

  // Output valid: set on accept, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  // Result payload, loaded only on accept so a stalled result holds.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_scl_lv_q <= scl_lv_d;
      res_scl_dr_q <= scl_dr_d;
      res_sda_lv_q <= sda_lv_d;
      res_sda_dr_q <= sda_dr_d;
      res_busy_q   <= busy_d;
      res_rej_q    <= rej_d;
      res_done_q   <= done_d;
      res_irq_q    <= event_d & irq_en_q;
      res_rbyte_q  <= rbyte_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_level_o = res_scl_lv_q;
  assign scl_drive_o = res_scl_dr_q;
  assign sda_level_o = res_sda_lv_q;
  assign sda_drive_o = res_sda_dr_q;
  assign busy_res_o  = res_busy_q;
  assign rejected_o  = res_rej_q;
  assign done_res_o  = res_done_q;
  assign irq_flags_o = res_irq_q;
  assign read_byte_o = res_rbyte_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the I2C master bit engine: random handshakes, scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import i2cmbe_pkg::*;

  // Command flag masks, built from the package bit positions.
  localparam logic [FlagW-1:0] FlStart = FlagW'(1 << CfStart);
  localparam logic [FlagW-1:0] FlStop  = FlagW'(1 << CfStop);
  localparam logic [FlagW-1:0] FlRead  = FlagW'(1 << CfRead);
  localparam logic [FlagW-1:0] FlTen   = FlagW'(1 << CfTen);

  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned WatchdogLimit = 1000;
  // Random items per random phase.
  localparam int unsigned PhaseItems = 60;

  // One input transaction: a tick or a command, plus the sampled bus levels.
  typedef struct {
    logic             mode;
    logic [FlagW-1:0] flags;
    logic [AdW-1:0]   ad;
    logic             sda;
    logic             scl;
  } bus_cmd_t;

  // One output transaction: pin drives and status.
  typedef struct {
    logic              scl_lv;
    logic              scl_dr;
    logic              sda_lv;
    logic              sda_dr;
    logic              busy;
    logic              rej;
    logic              done;
    logic [EventW-1:0] irq;
    logic [7:0]        rbyte;
  } pin_result_t;

  // Architectural state of the bit engine as the predictor keeps it.
  typedef struct {
    phase_e             ph;
    logic [ShiftW-1:0]  sh;
    logic [PtrW-1:0]    ptr;
    logic [FlagW-1:0]   pend;
    logic [EventW-1:0]  ev;
    logic               busy;
    logic               scl_lv;
    logic               scl_dr;
    logic               sda_lv;
    logic               sda_dr;
  } engine_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              mode_i = 1'b0;
  logic [FlagW-1:0]  command_flags_i = '0;
  logic [AdW-1:0]    address_or_data_i = '0;
  logic              sda_in_i = 1'b1;
  logic              scl_in_i = 1'b1;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              scl_level_o;
  logic              scl_drive_o;
  logic              sda_level_o;
  logic              sda_drive_o;
  logic              busy_res_o;
  logic              rejected_o;
  logic              done_res_o;
  logic [EventW-1:0] irq_flags_o;
  logic [7:0]        read_byte_o;
  logic              cfg_we_i = 1'b0;
  logic [EventW-1:0] cfg_wdata_i = '0;

  i2c_master_bit_engine uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .command_flags_i   (command_flags_i),
    .address_or_data_i (address_or_data_i),
    .sda_in_i          (sda_in_i),
    .scl_in_i          (scl_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .scl_level_o       (scl_level_o),
    .scl_drive_o       (scl_drive_o),
    .sda_level_o       (sda_level_o),
    .sda_drive_o       (sda_drive_o),
    .busy_res_o        (busy_res_o),
    .rejected_o        (rejected_o),
    .done_res_o        (done_res_o),
    .irq_flags_o       (irq_flags_o),
    .read_byte_o       (read_byte_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bus_cmd_t    pending_cmds[$];   // items waiting for the driver
  pin_result_t expected_pins[$];  // predicted results, oldest first
  engine_t     model_eng;         // predictor state, advanced on accepted items
  engine_t     plan_eng;          // look-ahead copy, advanced as items are queued
  logic [EventW-1:0] irq_en_shadow = '0;
  logic        calm = 1'b0;       // when set, neither side idles
  int unsigned mismatches = 0;
  int unsigned planned = 0;       // queued items that the block does not just ignore
  int unsigned quiet_cycles = 0;

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic engine_t engine_reset();
    engine_t s;
    s.ph     = PH_IDLE;
    s.sh     = '0;
    s.ptr    = '0;
    s.pend   = '0;
    s.ev     = '0;
    s.busy   = 1'b0;
    s.scl_lv = 1'b1;
    s.scl_dr = 1'b1;
    s.sda_lv = 1'b1;
    s.sda_dr = 1'b1;
    return s;
  endfunction

  // A data read (no start flag) shifts SDA into the byte instead of driving it.
  function automatic logic receiving(engine_t s);
    return s.pend[CfRead] && !s.pend[CfStart];
  endfunction

  // Run one half-bit phase; raise done when the command retires.
  function automatic void advance_phase(inout engine_t s, input logic sda, input logic scl,
                                        inout logic done);
    logic [3:0] idx;
    idx = 4'(s.ptr - 1'b1);
    case (s.ph)
      PH_START: begin
        // Pull SDA low with SCL left high.
        s.sda_lv = 1'b0;
        s.sda_dr = 1'b1;
        s.ev[EvStarted] = 1'b1;
        s.ph = PH_FALL_BIT;
      end
      PH_FALL_BIT: begin
        s.scl_lv = 1'b0;
        s.scl_dr = 1'b1;
        s.ph = PH_BIT;
      end
      PH_FALL_ACK: begin
        s.scl_lv = 1'b0;
        s.scl_dr = 1'b1;
        s.ph = PH_ACK0;
      end
      PH_BIT: begin
        if (receiving(s)) begin
          s.sda_dr = 1'b0;
          if (sda) s.sh[idx] = 1'b1;
        end else begin
          s.sda_dr = 1'b1;
          s.sda_lv = s.sh[idx];
        end
        s.scl_lv = 1'b1;
        s.scl_dr = 1'b1;
        s.ptr = s.ptr - 1'b1;
        // A byte ends after the ten-bit header or after the last bit.
        if (s.ptr == PtrHeaderEnd || s.ptr == PtrByteEnd) begin
          if (s.pend[CfStart]) s.ev[(s.ptr == PtrHeaderEnd) ? EvTen : EvAddr] = 1'b1;
          else s.ev[EvTxEmpty] = 1'b1;
          s.ph = PH_FALL_ACK;
        end else begin
          s.ph = PH_FALL_BIT;
        end
      end
      PH_ACK0: begin
        // Release both lines; hold here while the slave stretches the clock.
        s.sda_dr = 1'b0;
        s.scl_dr = 1'b0;
        if (scl) begin
          s.scl_lv = 1'b1;
          s.scl_dr = 1'b1;
          if (sda) s.ev[EvNack] = 1'b1;
          s.ph = PH_ACK1;
        end
      end
      PH_ACK1: begin
        if (sda) s.ev[EvNack] = 1'b1;
        s.scl_lv = 1'b0;
        s.scl_dr = 1'b1;
        s.sda_lv = 1'b0;
        s.sda_dr = 1'b1;
        // After the ten-bit header go straight to the low address byte.
        s.ph = (s.ptr == PtrHeaderEnd) ? PH_BIT : PH_AFTER;
      end
      PH_AFTER: begin
        if (s.pend[CfStop]) begin
          s.scl_lv = 1'b1;
          s.scl_dr = 1'b1;
          s.ph = PH_STOP1;
        end else begin
          s.busy = 1'b0;
          done = 1'b1;
          s.ph = PH_IDLE;
        end
      end
      PH_STOP1: begin
        s.sda_lv = 1'b1;
        s.sda_dr = 1'b1;
        s.busy = 1'b0;
        done = 1'b1;
        s.ph = PH_IDLE;
      end
      default: s.ph = PH_IDLE;
    endcase
  endfunction

  // Apply one input transaction and return the result it produces.
  function automatic pin_result_t bit_engine_step(inout engine_t s, input bus_cmd_t c,
                                                  input logic [EventW-1:0] mask);
    pin_result_t r;
    logic done;
    logic rej;
    logic rd;
    done = 1'b0;
    rej  = 1'b0;
    rd   = c.flags[CfRead];
    if (c.mode) begin
      if (s.busy) begin
        rej = 1'b1;
      end else begin
        s.busy = 1'b1;
        s.ev   = '0;
        s.pend = c.flags;
        if (c.flags[CfStart]) begin
          if (c.flags[CfTen]) begin
            s.sh  = {TenBitPrefix, c.ad[9:8], rd, c.ad[7:0]};
            s.ptr = PtrTenBit;
          end else begin
            s.sh  = {8'h00, c.ad[6:0], rd};
            s.ptr = PtrByte;
          end
          s.ph = PH_START;
        end else begin
          s.sh  = rd ? '0 : {8'h00, c.ad[7:0]};
          s.ptr = PtrByte;
          s.ph  = PH_BIT;
        end
        // The first phase runs on the command itself.
        advance_phase(s, c.sda, c.scl, done);
      end
    end else if (s.busy) begin
      advance_phase(s, c.sda, c.scl, done);
    end
    r.scl_lv = s.scl_lv;
    r.scl_dr = s.scl_dr;
    r.sda_lv = s.sda_lv;
    r.sda_dr = s.sda_dr;
    r.busy   = s.busy;
    r.rej    = rej;
    r.done   = done;
    r.irq    = s.ev & mask;
    r.rbyte  = receiving(s) ? s.sh[7:0] : 8'h00;
    return r;
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // ------------------------------------------------------------------
  // Driver: present queued items, predict each one as it is accepted
  // ------------------------------------------------------------------
  int unsigned send_gap = 0;
  bus_cmd_t    sent_cmd;
  pin_result_t sent_res;
  bus_cmd_t    next_cmd;
  logic        in_taken;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        // Rebuild the accepted payload from the pins still holding it.
        sent_cmd.mode  = mode_i;
        sent_cmd.flags = command_flags_i;
        sent_cmd.ad    = address_or_data_i;
        sent_cmd.sda   = sda_in_i;
        sent_cmd.scl   = scl_in_i;
        sent_res = bit_engine_step(model_eng, sent_cmd, irq_en_shadow);
        expected_pins.push_back(sent_res);
      end
      // Hold the payload while stalled; otherwise advance to the next item.
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          mode_i            <= next_cmd.mode;
          command_flags_i   <= next_cmd.flags;
          address_or_data_i <= next_cmd.ad;
          sda_in_i          <= next_cmd.sda;
          scl_in_i          <= next_cmd.scl;
          in_valid_i        <= 1'b1;
          send_gap = idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Monitor: compare each accepted result with the oldest prediction
  // ------------------------------------------------------------------
  int unsigned stall_left = 0;
  pin_result_t want;

  task automatic compare(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_pins.size() == 0) begin
          $error("result transaction with no prediction pending");
          mismatches++;
        end else begin
          want = expected_pins.pop_front();
          compare("scl_level", 8'(want.scl_lv), 8'(scl_level_o));
          compare("scl_drive", 8'(want.scl_dr), 8'(scl_drive_o));
          compare("sda_level", 8'(want.sda_lv), 8'(sda_level_o));
          compare("sda_drive", 8'(want.sda_dr), 8'(sda_drive_o));
          compare("busy_res", 8'(want.busy), 8'(busy_res_o));
          compare("rejected", 8'(want.rej), 8'(rejected_o));
          compare("done_res", 8'(want.done), 8'(done_res_o));
          compare("irq_flags", 8'(want.irq), 8'(irq_flags_o));
          compare("read_byte", want.rbyte, read_byte_o);
        end
      end
      // Stall in bursts drawn from the same gap profile as the sender.
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_len();
      end
    end
  end

  // Watchdog: drop the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  // Queue one item and advance the look-ahead copy so transfers can be sized.
  task automatic queue_item(input logic mode, input logic [FlagW-1:0] flags,
                            input logic [AdW-1:0] ad, input logic sda, input logic scl);
    bus_cmd_t c;
    c.mode  = mode;
    c.flags = flags;
    c.ad    = ad;
    c.sda   = sda;
    c.scl   = scl;
    if (mode || plan_eng.busy) planned++;
    void'(bit_engine_step(plan_eng, c, '0));
    pending_cmds.push_back(c);
  endtask

  // Issue one command and tick it to completion. The slave stretches SCL at
  // random and answers ACK or NACK at random; noise_pct of the ticks are
  // replaced by commands that must be refused.
  task automatic queue_transfer(input logic [FlagW-1:0] flags, input logic [AdW-1:0] ad,
                                input int unsigned noise_pct);
    queue_item(1'b1, flags, ad, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    while (plan_eng.busy) begin
      if ($urandom_range(0, 99) < noise_pct)
        queue_item(1'b1, FlagW'($urandom_range(0, 15)), AdW'($urandom_range(0, 1023)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else
        queue_item(1'b0, FlagW'($urandom_range(0, 15)), AdW'($urandom_range(0, 1023)),
                   1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0));
    end
  endtask

  // Wait until every item is sent and every result checked, then let the
  // pipeline settle. Look at the falling edge, once the driver's
  // updates of the rising edge have settled.
  task automatic drain();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_pins.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mask(input logic [EventW-1:0] value);
    @(posedge clk_i);
    cfg_we_i      <= 1'b1;
    cfg_wdata_i   <= value;
    irq_en_shadow <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
  endtask

  initial begin
    int unsigned goal;
    logic [EventW-1:0] masks[4];
    model_eng = engine_reset();
    plan_eng  = engine_reset();
    masks[0] = '0;
    masks[1] = EventW'($urandom_range(1, 30));
    masks[2] = '1;
    masks[3] = EventW'($urandom_range(1, 30));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: unmask everything and walk each kind of command once.
    write_mask('1);
    // Tick while idle changes nothing.
    queue_item(1'b0, '1, '1, 1'b1, 1'b1);
    // 7-bit address write with stop, all address bits set.
    queue_transfer(FlStart | FlStop, '1, 0);
    // 10-bit address read, all ones, with refused commands mixed in.
    queue_transfer(FlStart | FlTen | FlRead, '1, 30);
    // 10-bit address write to zero, no stop.
    queue_transfer(FlStart | FlTen, '0, 0);
    // Data byte 0xFF, no stop; then byte 0x00 with stop, the ten-bit flag ignored.
    queue_transfer('0, 10'h0FF, 0);
    queue_transfer(FlStop | FlTen, 10'h300, 0);
    // Data read with stop: SDA released, byte assembled from the bus.
    queue_transfer(FlRead | FlStop, '0, 0);
    queue_transfer(FlRead, '1, 10);
    drain();

    // Random phases, each under its own mask; idling is off in the third phase only.
    for (int p = 0; p < 4; p++) begin
      write_mask(masks[p]);
      calm = (p == 2);
      goal = planned + PhaseItems;
      while (planned < goal) begin
        if ($urandom_range(0, 99) < 85)
          queue_transfer(FlagW'($urandom_range(0, 15)), AdW'($urandom_range(0, 1023)), 5);
        else
          repeat ($urandom_range(1, 3))
            queue_item(1'b0, FlagW'($urandom_range(0, 15)), AdW'($urandom_range(0, 1023)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      // Pause the sender until every expected result has come back.
      drain();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/i2cmbe_pkg.sv
src/i2c_master_bit_engine.sv
tb/tb_top.sv
